[src/phsf_pkg.sv]
// Shared types and constants of the packet header source filter.
// No dependencies; the parser, datapath, controller and top level import this package.
package phsf_pkg;

  // Operation codes of an input beat
  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result kinds and table status codes
  localparam logic RK_VERDICT = 1'b0;
  localparam logic RK_TABLE   = 1'b1;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // Key field selection
  localparam logic [2:0] FS_MAC  = 3'd0;
  localparam logic [2:0] FS_VLAN = 3'd1;
  localparam logic [2:0] FS_IPV4 = 3'd2;
  localparam logic [2:0] FS_IPV6 = 3'd3;
  localparam logic [2:0] FS_UDP  = 3'd4;
  localparam logic [2:0] FS_TCP  = 3'd5;

  // Register indexes on the config port
  localparam logic REG_FIELD_SELECT = 1'b0;
  localparam logic REG_ALLOW_MODE   = 1'b1;

  // Header constants
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_IPV6  = 16'h86DD;
  localparam logic [15:0] TPID_CTAG = 16'h8100;
  localparam logic [15:0] TPID_STAG = 16'h88A8;
  localparam logic [11:0] VID_MASK  = 12'h0fff;
  localparam logic [7:0]  IP_UDP    = 8'd17;
  localparam logic [7:0]  IP_TCP    = 8'd6;
  localparam logic [7:0]  UDP_HDR   = 8'd8;
  localparam logic [7:0]  TCP_HDR   = 8'd20;

  // One table row
  typedef struct packed {
    logic        vld;
    logic [63:0] up;
    logic [63:0] lo;
  } phsf_row_t;

  // Controller to datapath
  typedef struct packed {
    logic take_byte;
    logic load_in_key;
    logic load_frame_key;
    logic scan_step;
    logic clear_step;
    logic wr_insert;
    logic wr_remove;
  } phsf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_ok;
    logic match_found;
    logic table_full;
    logic scan_last;
  } phsf_status_t;

endpackage

[src/phsf_item_if.sv]
// Input channel of the filter: one beat is a frame byte or a table operation.
// Standalone interface, no dependencies.
interface phsf_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [63:0] key_upper;
  logic [63:0] key_lower;

  modport source (output valid, operation, data_byte, last_byte, key_upper, key_lower,
                  input ready);
  modport sink (input valid, operation, data_byte, last_byte, key_upper, key_lower,
                output ready);
endinterface

[src/phsf_result_if.sv]
// Result channel of the filter: one beat is a frame verdict or a table status.
// Standalone interface, no dependencies.
interface phsf_result_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic       pass_frame;
  logic [1:0] table_status;

  modport source (output valid, result_kind, pass_frame, table_status, input ready);
  modport sink (input valid, result_kind, pass_frame, table_status, output ready);
endinterface

[src/phsf_parser.sv]
// Header parser: tracks the frame offset, ethertype, protocol and captures
// the selected key bytes. Depends on phsf_pkg.
module phsf_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic        last,
  input  logic        clear,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  field_select,
  output logic [63:0] key_upper,
  output logic [63:0] key_lower,
  output logic        key_ok
);
  import phsf_pkg::*;

  logic [6:0]  byte_offset;
  logic [15:0] ether_kind;
  logic [7:0]  ip_protocol;
  logic [6:0]  transport_offset;
  logic [63:0] captured_upper;
  logic [63:0] captured_lower;

  logic [6:0]  pos;
  logic [15:0] ether_next;
  logic [6:0]  transport_next;
  logic        in_win;
  logic        is_ip;
  logic [7:0]  len;
  logic [7:0]  t_ext;

  assign pos = byte_offset;

  always_comb begin
    ether_next = ether_kind;
    if (pos == 7'd12 || pos == 7'd13) begin
      ether_next = {ether_kind[7:0], data_byte};
    end
    transport_next = transport_offset;
    if (pos == 7'd14) begin
      if (ether_kind == ETH_IPV4) begin
        transport_next = 7'd14 + {1'b0, data_byte[3:0], 2'b00};
      end else if (ether_kind == ETH_IPV6) begin
        transport_next = 7'd54;
      end
    end
  end

  assign is_ip = (ether_kind == ETH_IPV4) || (ether_kind == ETH_IPV6);

  always_comb begin
    case (field_select)
      FS_MAC:  in_win = (pos >= 7'd6) && (pos <= 7'd11);
      FS_VLAN: in_win = (pos == 7'd14) || (pos == 7'd15);
      FS_IPV4: in_win = (pos >= 7'd26) && (pos <= 7'd29);
      FS_IPV6: in_win = (pos >= 7'd22) && (pos <= 7'd37);
      FS_UDP, FS_TCP: in_win = (pos >= 7'd14) && is_ip &&
                               ((pos == transport_next) ||
                                ({1'b0, pos} == {1'b0, transport_next} + 8'd1));
      default: in_win = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      byte_offset      <= '0;
      ether_kind       <= '0;
      ip_protocol      <= '0;
      transport_offset <= '0;
      captured_upper   <= '0;
      captured_lower   <= '0;
    end else if (take) begin
      ether_kind       <= ether_next;
      transport_offset <= transport_next;
      if ((pos == 7'd23 && ether_kind == ETH_IPV4) ||
          (pos == 7'd20 && ether_kind == ETH_IPV6)) begin
        ip_protocol <= data_byte;
      end
      if (in_win) begin
        captured_upper <= {captured_upper[55:0], captured_lower[63:56]};
        captured_lower <= {captured_lower[55:0], data_byte};
      end
      if (!last && byte_offset != 7'd127) begin
        byte_offset <= byte_offset + 7'd1;
      end
    end
  end

  // Verdict side: frame length counts the last byte too
  assign len   = {1'b0, byte_offset} + 8'd1;
  assign t_ext = {1'b0, transport_offset};

  function automatic logic port_ok(input logic [7:0] proto, input logic [7:0] hdr,
                                   input logic [15:0] ek, input logic [7:0] ln,
                                   input logic [7:0] ipp, input logic [7:0] t);
    logic r;
    r = 1'b0;
    if (ek == ETH_IPV4) begin
      r = (ln >= 8'd34) && (ipp == proto) && (ln >= t + hdr);
    end else if (ek == ETH_IPV6) begin
      r = (ln >= 8'd54) && (ipp == proto) && (ln >= 8'd54 + hdr);
    end
    return r;
  endfunction

  always_comb begin
    key_upper = '0;
    key_lower = '0;
    case (field_select)
      FS_MAC: begin
        key_ok    = len >= 8'd14;
        key_lower = {16'h0, captured_lower[47:0]};
      end
      FS_VLAN: begin
        key_ok    = (len >= 8'd18) && (ether_kind == TPID_CTAG || ether_kind == TPID_STAG);
        key_lower = {52'h0, captured_lower[11:0] & VID_MASK};
      end
      FS_IPV4: begin
        key_ok    = (len >= 8'd34) && (ether_kind == ETH_IPV4);
        key_lower = {32'h0, captured_lower[31:0]};
      end
      FS_IPV6: begin
        key_ok    = (len >= 8'd54) && (ether_kind == ETH_IPV6);
        key_upper = captured_upper;
        key_lower = captured_lower;
      end
      FS_UDP: begin
        key_ok    = port_ok(IP_UDP, UDP_HDR, ether_kind, len, ip_protocol, t_ext);
        key_lower = {48'h0, captured_lower[15:0]};
      end
      FS_TCP: begin
        key_ok    = port_ok(IP_TCP, TCP_HDR, ether_kind, len, ip_protocol, t_ext);
        key_lower = {48'h0, captured_lower[15:0]};
      end
      default: key_ok = 1'b0;
    endcase
  end

endmodule

[src/phsf_datapath.sv]
// Datapath: header parser, search key, key table memory with a single read
// port, sequential probe, entry count. Depends on phsf_pkg and phsf_parser.
module phsf_datapath #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  phsf_pkg::phsf_cmd_t   cmd,
  output phsf_pkg::phsf_status_t status,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic [63:0]           key_upper,
  input  logic [63:0]           key_lower,
  input  logic [2:0]            field_select
);
  import phsf_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic [63:0] frame_up;
  logic [63:0] frame_lo;
  logic        frame_ok;

  phsf_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (cmd.take_byte),
    .last         (last_byte),
    .clear        (cmd.load_frame_key),
    .data_byte    (data_byte),
    .field_select (field_select),
    .key_upper    (frame_up),
    .key_lower    (frame_lo),
    .key_ok       (frame_ok)
  );

  phsf_row_t mem [TABLE_ENTRIES];
  phsf_row_t rd_row;
  phsf_row_t wr_row;
  logic      we;
  logic [IW-1:0] waddr;

  logic [63:0]   skey_up;
  logic [63:0]   skey_lo;
  logic [IW-1:0] idx;
  logic          probe_v;
  logic [IW-1:0] probe_idx;
  logic          match_found;
  logic [IW-1:0] match_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [CW-1:0] entry_count;
  logic          scan_last;
  logic          probe_hit;
  logic          new_search;

  assign scan_last  = idx == IW'(TABLE_ENTRIES - 1);
  assign new_search = cmd.load_in_key || cmd.load_frame_key;

  always_comb begin
    we     = cmd.clear_step || cmd.wr_insert || cmd.wr_remove;
    waddr  = idx;
    wr_row = '0;
    if (cmd.wr_insert) begin
      waddr  = free_idx;
      wr_row = '{vld: 1'b1, up: skey_up, lo: skey_lo};
    end else if (cmd.wr_remove) begin
      waddr = match_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wr_row;
    end
    if (cmd.scan_step) begin
      rd_row <= mem[idx];
    end
  end

  assign probe_hit = probe_v && rd_row.vld && rd_row.up == skey_up && rd_row.lo == skey_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      probe_v     <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      entry_count <= '0;
    end else begin
      probe_v <= cmd.scan_step;
      if (cmd.scan_step || cmd.clear_step) begin
        idx <= scan_last ? '0 : idx + IW'(1);
      end
      if (new_search) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (probe_v) begin
        if (probe_hit && !match_found) begin
          match_found <= 1'b1;
        end
        if (!rd_row.vld && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.wr_insert) begin
        entry_count <= entry_count + CW'(1);
      end else if (cmd.wr_remove) begin
        entry_count <= entry_count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_idx <= idx;
    if (probe_v && probe_hit && !match_found) begin
      match_idx <= probe_idx;
    end
    if (probe_v && !rd_row.vld && !free_found) begin
      free_idx <= probe_idx;
    end
    if (cmd.load_in_key) begin
      skey_up <= key_upper;
      skey_lo <= key_lower;
    end else if (cmd.load_frame_key) begin
      skey_up <= frame_up;
      skey_lo <= frame_lo;
    end
  end

  assign status.frame_ok    = frame_ok;
  assign status.match_found = match_found;
  assign status.table_full  = entry_count == CW'(TABLE_ENTRIES);
  assign status.scan_last   = scan_last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_ENTRIES))
    else $error("entry count above table size");
  a_insert_absent: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_insert |-> !match_found && !status.table_full)
    else $error("insert of present key or into full table");
  a_insert_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_insert |-> free_found)
    else $error("insert without a free slot");
  a_remove_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_remove |-> match_found && entry_count != '0)
    else $error("remove without a matching entry");

endmodule

[src/phsf_ctrl.sv]
// Controller: sequences clear pass, frame bytes, table probes and results,
// and holds the result register. Depends on phsf_pkg.
module phsf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             operation,
  input  logic                   last_byte,
  input  logic                   allow_mode,
  output phsf_pkg::phsf_cmd_t    cmd,
  input  phsf_pkg::phsf_status_t status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   result_kind,
  output logic                   pass_frame,
  output logic [1:0]             table_status
);
  import phsf_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EVAL, S_SCAN, S_DRAIN, S_DECIDE, S_FINISH
  } state_t;

  state_t     state;
  logic [1:0] op;
  logic       res_kind;
  logic       res_pass;
  logic [1:0] res_status;
  logic       fire;
  logic       hit;

  assign in_ready = state == S_IDLE;
  assign fire     = in_valid && in_ready;
  assign hit      = status.match_found;

  always_comb begin
    cmd                = '0;
    cmd.take_byte      = fire && operation == OP_BYTE;
    cmd.load_in_key    = fire && (operation == OP_ADD || operation == OP_REMOVE);
    cmd.load_frame_key = state == S_EVAL;
    cmd.scan_step      = state == S_SCAN;
    cmd.clear_step     = state == S_CLEAR;
    cmd.wr_insert      = state == S_DECIDE && op == OP_ADD && !hit && !status.table_full;
    cmd.wr_remove      = state == S_DECIDE && op == OP_REMOVE && hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      // in S_FINISH the output register is handled below
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (status.scan_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (fire) begin
            op <= operation;
            if (operation == OP_BYTE) begin
              if (last_byte) begin
                state <= S_EVAL;
              end
            end else if (operation == OP_ADD || operation == OP_REMOVE) begin
              state <= S_SCAN;
            end
          end
        end
        S_EVAL: begin
          // frame without its key skips the probe; match flag is cleared
          state <= status.frame_ok ? S_SCAN : S_DECIDE;
        end
        S_SCAN: begin
          if (status.scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_DECIDE;
        S_DECIDE: begin
          if (op == OP_BYTE) begin
            res_kind   <= RK_VERDICT;
            res_pass   <= allow_mode ? hit : !hit;
            res_status <= ST_DONE;
          end else begin
            res_kind <= RK_TABLE;
            res_pass <= 1'b0;
            if (op == OP_ADD && !hit && status.table_full) begin
              res_status <= ST_FULL;
            end else if (op == OP_REMOVE && !hit) begin
              res_status <= ST_ABSENT;
            end else begin
              res_status <= ST_DONE;
            end
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            result_kind  <= res_kind;
            pass_frame   <= res_pass;
            table_status <= res_status;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/packet_header_source_filter_core.sv]
// Top level of the packet header source filter: config registers, controller
// and datapath. Depends on phsf_pkg, phsf_item_if, phsf_result_if,
// phsf_ctrl and phsf_datapath.
//
// Usage:
//  - in_item carries one beat per item: a frame byte (operation byte, with
//    last_byte on the final byte), an add key or a remove key (128-bit key).
//  - out_result gives one beat per frame (verdict: pass_frame) and one per
//    table operation (table_status: done, full, not present).
//  - APB port: field_select at 0x0, allow_mode at 0x4; write only while idle.
// Sequencing:
//  - Non-final frame bytes stream back to back.
//  - A final byte starts a probe of every table row when the header holds the
//    key (one table read per cycle through the single memory read port),
//    else goes straight to the verdict. Add/remove also probe every row.
// Reset:
//  - rst clears the config, frame state and count, then a clearing pass
//    wipes every table row; no beat is accepted meanwhile.
// Back-pressure:
//  - A result waits in the output register while in_ready stays up; the
//    block only holds the next result until the receiver takes the last one.
module packet_header_source_filter_core #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  phsf_item_if.sink   in_item,
  phsf_result_if.source out_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import phsf_pkg::*;

  logic [2:0]   field_select;
  logic         allow_mode;
  phsf_cmd_t    cmd;
  phsf_status_t status;

  // Config registers: register index is address bit 2
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_select <= FS_MAC;
      allow_mode   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_FIELD_SELECT) begin
        field_select <= pwdata[2:0];
      end else begin
        allow_mode <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_ALLOW_MODE) begin
      prdata = {31'h0, allow_mode};
    end else begin
      prdata = {29'h0, field_select};
    end
  end

  phsf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_item.valid),
    .in_ready     (in_item.ready),
    .operation    (in_item.operation),
    .last_byte    (in_item.last_byte),
    .allow_mode   (allow_mode),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_result.valid),
    .out_ready    (out_result.ready),
    .result_kind  (out_result.result_kind),
    .pass_frame   (out_result.pass_frame),
    .table_status (out_result.table_status)
  );

  // Datapath samples field_select every byte and again at the verdict
  phsf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .data_byte    (in_item.data_byte),
    .last_byte    (in_item.last_byte),
    .key_upper    (in_item.key_upper),
    .key_lower    (in_item.key_lower),
    .field_select (field_select)
  );

endmodule
